@@ rtl/core/pc4_pkg.sv @@
`timescale 1ns / 1ps

package pc4_pkg;

    // Value format: signed Q16.16 in a VALUE_W-bit word.
    localparam int VALUE_W   = 32;
    localparam int FRAC_BITS = 16;

    // Configuration registers are 32-bit unsigned; the weights and dt carry
    // CFG_W fraction bits.
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_DT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_POS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_VEL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_DT = 2'd3;

    localparam logic MODE_PREDICT = 1'b0;
    localparam logic MODE_CORRECT = 1'b1;

    // Coefficient sums reach at most 56 times the largest value, so six
    // extra bits hold them exactly.
    localparam int SUM_W = VALUE_W + 6;
    localparam int MAG_W = SUM_W - 1;
    localparam int HI_W  = MAG_W - VALUE_W;
    localparam int NP_W  = SUM_W + 1;
    localparam int T3_W  = VALUE_W + CFG_W - FRAC_BITS;
    localparam int NV_W  = ((T3_W + 1 > SUM_W) ? T3_W + 1 : SUM_W) + 1;

    localparam int NSTAGE = 10;

    localparam int IN_DATA_W  = ((7 * VALUE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((6 * VALUE_W + 7) / 8) * 8;

    localparam int COEF_W = 8;

    // Rows are indexed by the mode bit: predict first, then correct.
    localparam logic signed [COEF_W-1:0] POS_COEF [2][3] = '{
        '{8'sd19, -8'sd10, 8'sd3},
        '{8'sd3,  8'sd10,  -8'sd1}
    };
    localparam logic signed [COEF_W-1:0] VEL_COEF [2][3] = '{
        '{8'sd27, -8'sd22, 8'sd7},
        '{8'sd7,  8'sd6,   -8'sd1}
    };

    typedef struct packed {
        logic [CFG_W-1:0] step_dt;
        logic [CFG_W-1:0] weight_pos;
        logic [CFG_W-1:0] weight_vel;
        logic [CFG_W-1:0] inv_step_dt;
    } cfg_t;

    typedef struct packed {
        logic                      mode;
        logic signed [VALUE_W-1:0] position;
        logic signed [VALUE_W-1:0] velocity;
        logic signed [VALUE_W-1:0] position_prev;
        logic signed [VALUE_W-1:0] velocity_prev;
        logic signed [VALUE_W-1:0] accel_now;
        logic signed [VALUE_W-1:0] accel_1;
        logic signed [VALUE_W-1:0] accel_2;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] new_position;
        logic signed [VALUE_W-1:0] new_velocity;
        logic signed [VALUE_W-1:0] new_position_prev;
        logic signed [VALUE_W-1:0] new_velocity_prev;
        logic signed [VALUE_W-1:0] new_accel_1;
        logic signed [VALUE_W-1:0] new_accel_2;
        logic                      overflow;
    } out_t;

endpackage

@@ rtl/core/pc4_component_integrator_unit.sv @@
`timescale 1ns / 1ps

// Fourth-order predictor-corrector step for one scalar component (a position
// or a quaternion component) of one particle. Each input transaction carries
// the mode bit in tuser (0 predict, 1 correct) and the current position and
// velocity, the stored previous position and velocity, and the three latest
// accelerations in tdata, all signed Q16.16. The result transaction carries
// the new position and velocity, the values to store back as previous
// position and velocity, the shifted acceleration history, and in tuser a
// flag that is set when either new value was saturated. The block keeps no
// state between transactions, so a new transaction is accepted every clock
// cycle while the pipeline is not backed up by a stalled output; each item
// passes through the ten-stage arithmetic pipeline, whose depth is set by
// the two rounds of 32 by 32 multiplication, each with its rescaling and
// saturation. Every stage carries a valid bit and holds its contents only
// when the stage after it is full and stalled, so empty stages keep filling
// while a finished result waits on the output. The four configuration
// registers (dt, dt squared over 24, dt over 24 and 1/dt) are written
// through the cfg channel, which is always ready, and must only be changed
// while no transaction is in flight.
module pc4_component_integrator_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // position, velocity, position_prev, velocity_prev, accel_now, accel_1,
    // accel_2, from the lowest bit up.
    input  logic [pc4_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // mode.
    input  logic [0:0]                           s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // new_position, new_velocity, new_position_prev, new_velocity_prev,
    // new_accel_1, new_accel_2, from the lowest bit up.
    output logic [pc4_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // overflow.
    output logic [0:0]                           m_axis_tuser,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pc4_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pc4_pkg::CFG_W-1:0]            cfg_data
);

    localparam int VW = pc4_pkg::VALUE_W;
    localparam int NS = pc4_pkg::NSTAGE;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    pc4_pkg::cfg_t  cfg_reg;
    pc4_pkg::in_t   in_item;
    pc4_pkg::out_t  out_item;

    logic [NS-1:0]  valid_reg, valid_next;
    logic [NS-1:0]  stage_en;

    // Configuration registers. Writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pc4_pkg::REG_STEP_DT:     cfg_reg.step_dt     <= cfg_data;
                pc4_pkg::REG_WEIGHT_POS:  cfg_reg.weight_pos  <= cfg_data;
                pc4_pkg::REG_WEIGHT_VEL:  cfg_reg.weight_vel  <= cfg_data;
                pc4_pkg::REG_INV_STEP_DT: cfg_reg.inv_step_dt <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or when the stage after it moves on.
    // The last stage moves on when the consumer takes the result.
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[NS-1];

    // Unpack the input transaction.
    always_comb begin
        in_item.mode          = s_axis_tuser[0];
        in_item.position      = s_axis_tdata[0*VW +: VW];
        in_item.velocity      = s_axis_tdata[1*VW +: VW];
        in_item.position_prev = s_axis_tdata[2*VW +: VW];
        in_item.velocity_prev = s_axis_tdata[3*VW +: VW];
        in_item.accel_now     = s_axis_tdata[4*VW +: VW];
        in_item.accel_1       = s_axis_tdata[5*VW +: VW];
        in_item.accel_2       = s_axis_tdata[6*VW +: VW];
    end

    pc4_datapath u_datapath (
        .aclk     (aclk),
        .stage_en (stage_en),
        .cfg      (cfg_reg),
        .in_item  (in_item),
        .out_item (out_item)
    );

    // Pack the result transaction, zero-filled up to whole bytes.
    assign m_axis_tdata = pc4_pkg::OUT_DATA_W'({out_item.new_accel_2,
                                               out_item.new_accel_1,
                                               out_item.new_velocity_prev,
                                               out_item.new_position_prev,
                                               out_item.new_velocity,
                                               out_item.new_position});
    assign m_axis_tuser = out_item.overflow;

    // The number of transactions in flight changes only by what enters and
    // what leaves.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !(m_axis_tvalid && m_axis_tready))
        |=> $countones(valid_reg) == $past($countones(valid_reg)) + 1)
        else $error("pipeline occupancy did not grow on an accepted input");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!(s_axis_tvalid && s_axis_tready) && m_axis_tvalid && m_axis_tready)
        |=> $countones(valid_reg) + 1 == $past($countones(valid_reg)))
        else $error("pipeline occupancy did not shrink on a delivered result");

    // A flagged result must hold at least one value at a range limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0])
        |-> (out_item.new_position == VMAX || out_item.new_position == VMIN ||
             out_item.new_velocity == VMAX || out_item.new_velocity == VMIN))
        else $error("overflow flagged without a saturated result");

    // With the output stage empty nothing can hold the input back.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[NS-1] |-> s_axis_tready)
        else $error("input stalled while the output stage is empty");

endmodule

@@ rtl/core/pc4_datapath.sv @@
`timescale 1ns / 1ps

// Ten-stage arithmetic pipeline. Stage k loads when stage_en[k-1] is high.
module pc4_datapath (
    input  logic                                aclk,
    input  logic [pc4_pkg::NSTAGE-1:0]          stage_en,
    input  pc4_pkg::cfg_t                       cfg,
    input  pc4_pkg::in_t                        in_item,
    output pc4_pkg::out_t                       out_item
);

    localparam int VW    = pc4_pkg::VALUE_W;
    localparam int CW    = pc4_pkg::CFG_W;
    localparam int FB    = pc4_pkg::FRAC_BITS;
    localparam int SUM_W = pc4_pkg::SUM_W;
    localparam int MAG_W = pc4_pkg::MAG_W;
    localparam int HI_W  = pc4_pkg::HI_W;
    localparam int NP_W  = pc4_pkg::NP_W;
    localparam int T3_W  = pc4_pkg::T3_W;
    localparam int NV_W  = pc4_pkg::NV_W;
    localparam int NS    = pc4_pkg::NSTAGE;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

    // Fields that only ride along with the item.
    typedef struct packed {
        logic signed [VW-1:0] pp;
        logic signed [VW-1:0] pv;
        logic signed [VW-1:0] a1;
        logic signed [VW-1:0] a2;
    } carry_t;

    carry_t carry_next;
    carry_t carry_reg [NS];

    // Stage 1: operand selection and coefficient sums.
    logic                    sel;
    logic signed [VW-1:0]    bvel;
    logic signed [SUM_W-1:0] acc0, acc1, acc2;
    logic signed [SUM_W-1:0] p_pred, p_corr, v_pred, v_corr;
    logic signed [SUM_W-1:0] s1_psum_next, s1_vsum_next;
    logic [VW-1:0]           s1_vmag_next;
    logic                    s1_vneg_next;
    logic signed [SUM_W-1:0] s1_psum_reg, s1_vsum_reg;
    logic [VW-1:0]           s1_vmag_reg;
    logic                    s1_vneg_reg;

    // Both coefficient sets are formed with constant factors, then the mode
    // picks one.
    always_comb begin
        sel           = in_item.mode;
        carry_next.pp = sel ? in_item.position_prev : in_item.position;
        carry_next.pv = sel ? in_item.velocity_prev : in_item.velocity;
        carry_next.a1 = sel ? in_item.accel_1 : in_item.accel_now;
        carry_next.a2 = sel ? in_item.accel_2 : in_item.accel_1;
        bvel          = carry_next.pv;
        acc0          = SUM_W'(in_item.accel_now);
        acc1          = SUM_W'(in_item.accel_1);
        acc2          = SUM_W'(in_item.accel_2);
        p_pred = acc0 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_PREDICT][0])
               + acc1 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_PREDICT][1])
               + acc2 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_PREDICT][2]);
        p_corr = acc0 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_CORRECT][0])
               + acc1 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_CORRECT][1])
               + acc2 * SUM_W'(pc4_pkg::POS_COEF[pc4_pkg::MODE_CORRECT][2]);
        v_pred = acc0 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_PREDICT][0])
               + acc1 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_PREDICT][1])
               + acc2 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_PREDICT][2]);
        v_corr = acc0 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_CORRECT][0])
               + acc1 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_CORRECT][1])
               + acc2 * SUM_W'(pc4_pkg::VEL_COEF[pc4_pkg::MODE_CORRECT][2]);
        s1_psum_next  = sel ? p_corr : p_pred;
        s1_vsum_next  = sel ? v_corr : v_pred;
        s1_vneg_next  = bvel[VW-1];
        s1_vmag_next  = bvel[VW-1] ? VW'(-bvel) : VW'(bvel);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s1_psum_reg <= s1_psum_next;
            s1_vsum_reg <= s1_vsum_next;
            s1_vmag_reg <= s1_vmag_next;
            s1_vneg_reg <= s1_vneg_next;
        end
    end

    // Stage 2: magnitudes of the coefficient sums.
    logic [MAG_W-1:0] s2_pmag_next, s2_vsmag_next;
    logic [MAG_W-1:0] s2_pmag_reg, s2_vsmag_reg;
    logic             s2_pneg_reg, s2_vsneg_reg, s2_vneg_reg;
    logic [VW-1:0]    s2_vmag_reg;

    always_comb begin
        s2_pmag_next  = s1_psum_reg[SUM_W-1] ? MAG_W'(-s1_psum_reg) : MAG_W'(s1_psum_reg);
        s2_vsmag_next = s1_vsum_reg[SUM_W-1] ? MAG_W'(-s1_vsum_reg) : MAG_W'(s1_vsum_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            s2_pmag_reg  <= s2_pmag_next;
            s2_vsmag_reg <= s2_vsmag_next;
            s2_pneg_reg  <= s1_psum_reg[SUM_W-1];
            s2_vsneg_reg <= s1_vsum_reg[SUM_W-1];
            s2_vmag_reg  <= s1_vmag_reg;
            s2_vneg_reg  <= s1_vneg_reg;
        end
    end

    // Stage 3: unsigned products. The wide sums are split into a low word and
    // a few high bits so that no multiplier exceeds 32 by 32.
    logic [VW+CW-1:0]   s3_p1_next, s3_p2lo_next, s3_p4lo_next;
    logic [HI_W+CW-1:0] s3_p2hi_next, s3_p4hi_next;
    logic [VW+CW-1:0]   s3_p1_reg, s3_p2lo_reg, s3_p4lo_reg;
    logic [HI_W+CW-1:0] s3_p2hi_reg, s3_p4hi_reg;
    logic               s3_vneg_reg, s3_pneg_reg, s3_vsneg_reg;

    always_comb begin
        s3_p1_next   = s2_vmag_reg * cfg.step_dt;
        s3_p2lo_next = s2_pmag_reg[VW-1:0] * cfg.weight_pos;
        s3_p2hi_next = s2_pmag_reg[MAG_W-1:VW] * cfg.weight_pos;
        s3_p4lo_next = s2_vsmag_reg[VW-1:0] * cfg.weight_vel;
        s3_p4hi_next = s2_vsmag_reg[MAG_W-1:VW] * cfg.weight_vel;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            s3_p1_reg    <= s3_p1_next;
            s3_p2lo_reg  <= s3_p2lo_next;
            s3_p2hi_reg  <= s3_p2hi_next;
            s3_p4lo_reg  <= s3_p4lo_next;
            s3_p4hi_reg  <= s3_p4hi_next;
            s3_vneg_reg  <= s2_vneg_reg;
            s3_pneg_reg  <= s2_pneg_reg;
            s3_vsneg_reg <= s2_vsneg_reg;
        end
    end

    // Stage 4: drop the fraction bits (truncating the magnitude, which rounds
    // toward zero) and put the sign back.
    logic [VW-1:0]           m1;
    logic [MAG_W-1:0]        m2, m4;
    logic signed [VW:0]      s4_t1_next, s4_t1_reg;
    logic signed [SUM_W-1:0] s4_t2_next, s4_t4_next, s4_t2_reg, s4_t4_reg;

    always_comb begin
        m1 = s3_p1_reg[VW+CW-1:CW];
        m2 = MAG_W'(s3_p2hi_reg) + MAG_W'(s3_p2lo_reg >> CW);
        m4 = MAG_W'(s3_p4hi_reg) + MAG_W'(s3_p4lo_reg >> CW);
        s4_t1_next = s3_vneg_reg  ? -$signed({1'b0, m1}) : $signed({1'b0, m1});
        s4_t2_next = s3_pneg_reg  ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
        s4_t4_next = s3_vsneg_reg ? -$signed({1'b0, m4}) : $signed({1'b0, m4});
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            s4_t1_reg <= s4_t1_next;
            s4_t2_reg <= s4_t2_next;
            s4_t4_reg <= s4_t4_next;
        end
    end

    // Stage 5: unsaturated new position.
    logic signed [NP_W-1:0]  s5_np_next, s5_np_reg;
    logic signed [SUM_W-1:0] s5_t4_reg;

    always_comb begin
        s5_np_next = NP_W'(carry_reg[3].pp) + NP_W'(s4_t1_reg) + NP_W'(s4_t2_reg);
    end

    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            s5_np_reg <= s5_np_next;
            s5_t4_reg <= s4_t4_reg;
        end
    end

    // Stage 6: saturate the position.
    logic signed [VW-1:0]    s6_np_next, s6_np_reg;
    logic                    s6_ovf_next, s6_ovf_reg;
    logic signed [SUM_W-1:0] s6_t4_reg;

    always_comb begin
        s6_ovf_next = 1'b1;
        if (s5_np_reg > NP_W'(VMAX)) begin
            s6_np_next = VMAX;
        end else if (s5_np_reg < NP_W'(VMIN)) begin
            s6_np_next = VMIN;
        end else begin
            s6_np_next  = VW'(s5_np_reg);
            s6_ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[5]) begin
            s6_np_reg  <= s6_np_next;
            s6_ovf_reg <= s6_ovf_next;
            s6_t4_reg  <= s5_t4_reg;
        end
    end

    // Stage 7: magnitude and sign of the position difference.
    logic signed [VW:0]      d, nd;
    logic [VW-1:0]           s7_dmag_next, s7_dmag_reg;
    logic                    s7_dneg_reg, s7_ovf_reg;
    logic signed [VW-1:0]    s7_np_reg;
    logic signed [SUM_W-1:0] s7_t4_reg;

    always_comb begin
        d  = (VW+1)'(s6_np_reg) - (VW+1)'(carry_reg[5].pp);
        nd = (VW+1)'(carry_reg[5].pp) - (VW+1)'(s6_np_reg);
        s7_dmag_next = d[VW] ? nd[VW-1:0] : d[VW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (stage_en[6]) begin
            s7_dmag_reg <= s7_dmag_next;
            s7_dneg_reg <= d[VW];
            s7_ovf_reg  <= s6_ovf_reg;
            s7_np_reg   <= s6_np_reg;
            s7_t4_reg   <= s6_t4_reg;
        end
    end

    // Stage 8: difference times the reciprocal step.
    logic [VW+CW-1:0]        s8_p3_next, s8_p3_reg;
    logic                    s8_dneg_reg, s8_ovf_reg;
    logic signed [VW-1:0]    s8_np_reg;
    logic signed [SUM_W-1:0] s8_t4_reg;

    always_comb begin
        s8_p3_next = s7_dmag_reg * cfg.inv_step_dt;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[7]) begin
            s8_p3_reg   <= s8_p3_next;
            s8_dneg_reg <= s7_dneg_reg;
            s8_ovf_reg  <= s7_ovf_reg;
            s8_np_reg   <= s7_np_reg;
            s8_t4_reg   <= s7_t4_reg;
        end
    end

    // Stage 9: unsaturated new velocity.
    logic [T3_W-1:0]        m3;
    logic signed [NV_W-1:0] s9_nv_next, s9_nv_reg;
    logic                   s9_ovf_reg;
    logic signed [VW-1:0]   s9_np_reg;

    always_comb begin
        m3 = s8_p3_reg[VW+CW-1:FB];
        if (s8_dneg_reg) begin
            s9_nv_next = NV_W'(s8_t4_reg) - NV_W'(m3);
        end else begin
            s9_nv_next = NV_W'(s8_t4_reg) + NV_W'(m3);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[8]) begin
            s9_nv_reg  <= s9_nv_next;
            s9_ovf_reg <= s8_ovf_reg;
            s9_np_reg  <= s8_np_reg;
        end
    end

    // Stage 10: saturate the velocity; this is the output register.
    logic signed [VW-1:0] out_nv_next, out_nv_reg, out_np_reg;
    logic                 out_ovf_next, out_ovf_reg;

    always_comb begin
        out_ovf_next = 1'b1;
        if (s9_nv_reg > NV_W'(VMAX)) begin
            out_nv_next = VMAX;
        end else if (s9_nv_reg < NV_W'(VMIN)) begin
            out_nv_next = VMIN;
        end else begin
            out_nv_next  = VW'(s9_nv_reg);
            out_ovf_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[9]) begin
            out_nv_reg  <= out_nv_next;
            out_np_reg  <= s9_np_reg;
            out_ovf_reg <= out_ovf_next | s9_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            carry_reg[0] <= carry_next;
        end
        for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    always_comb begin
        out_item.new_position      = out_np_reg;
        out_item.new_velocity      = out_nv_reg;
        out_item.new_position_prev = carry_reg[NS-1].pp;
        out_item.new_velocity_prev = carry_reg[NS-1].pv;
        out_item.new_accel_1       = carry_reg[NS-1].a1;
        out_item.new_accel_2       = carry_reg[NS-1].a2;
        out_item.overflow          = out_ovf_reg;
    end

endmodule
